@@ design/sbot_pkg.sv @@
// shared types and constants for the bulk-only transport engine
package sbot_pkg;

  localparam logic [31:0] CBW_SIG = 32'h4342_5355;
  localparam logic [6:0]  CBW_LEN = 7'd31;

  // configuration register indexes
  localparam logic [1:0] REG_MEDIUM_READY = 2'd0;
  localparam logic [1:0] REG_WRITABLE     = 2'd1;
  localparam logic [1:0] REG_CAPACITY     = 2'd2;

  typedef enum logic [1:0] {
    FUNC_OUT   = 2'd0,
    FUNC_IN    = 2'd1,
    FUNC_RESET = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ACT_NAK   = 3'd0,
    ACT_READ  = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_RESP  = 3'd3,
    ACT_CSW   = 3'd4
  } act_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_READ   = 5'b00010,
    PH_WRITE  = 5'b00100,
    PH_RESP   = 5'b01000,
    PH_STATUS = 5'b10000
  } phase_t;

  localparam logic [7:0] OP_TUR   = 8'h00;
  localparam logic [7:0] OP_SENSE = 8'h03;
  localparam logic [7:0] OP_INQ   = 8'h12;
  localparam logic [7:0] OP_MS6   = 8'h1A;
  localparam logic [7:0] OP_SSU   = 8'h1B;
  localparam logic [7:0] OP_PAMR  = 8'h1E;
  localparam logic [7:0] OP_CAP   = 8'h25;
  localparam logic [7:0] OP_READ  = 8'h28;
  localparam logic [7:0] OP_WRITE = 8'h2A;
  localparam logic [7:0] OP_MS10  = 8'h5A;

  localparam logic [2:0] RK_SENSE = 3'd0;
  localparam logic [2:0] RK_INQ   = 3'd1;
  localparam logic [2:0] RK_MS6   = 3'd2;
  localparam logic [2:0] RK_MS10  = 3'd3;
  localparam logic [2:0] RK_CAP   = 3'd4;

  // classified event kinds from the front part
  typedef enum logic [2:0] {
    EV_NAK   = 3'd0,
    EV_RESET = 3'd1,
    EV_OUT   = 3'd2,
    EV_CBW   = 3'd3,
    EV_IN    = 3'd4
  } ev_t;

  // one classified event
  typedef struct packed {
    ev_t         kind;
    logic [6:0]  len;
    logic [31:0] tag;
    logic [31:0] dlen;
    logic [7:0]  op;
    logic [31:0] lba;
    logic [15:0] nblk;
  } event_t;

  // one result beat
  typedef struct packed {
    act_t        action;
    logic [31:0] block_address;
    logic [8:0]  byte_offset;
    logic [6:0]  packet_length;
    logic [2:0]  response_kind;
    logic [63:0] response_word;
    logic [31:0] status_tag;
    logic [31:0] status_residue;
    logic        status_code;
    logic        last;
  } result_t;

endpackage

@@ design/sbot_front.sv @@
// front part: takes input beats, classifies them, two-entry queue
module sbot_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [6:0]           rx_length,
  input  logic [31:0]          signature,
  input  logic [31:0]          cbw_tag,
  input  logic [31:0]          cbw_data_length,
  input  logic [7:0]           scsi_opcode,
  input  logic [31:0]          start_lba,
  input  logic [15:0]          block_count,
  output logic                 ev_valid,
  input  logic                 ev_ready,
  output sbot_pkg::event_t     ev
);
  import sbot_pkg::*;

  event_t     q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  event_t     cls;
  logic       push, pop;

  // classify the incoming beat
  always_comb begin
    cls      = '0;
    cls.len  = rx_length;
    cls.tag  = cbw_tag;
    cls.dlen = cbw_data_length;
    cls.op   = scsi_opcode;
    cls.lba  = start_lba;
    cls.nblk = block_count;
    unique case (func_t'(func))
      FUNC_OUT: begin
        if (rx_length == CBW_LEN && signature == CBW_SIG) cls.kind = EV_CBW;
        else cls.kind = EV_OUT;
      end
      FUNC_IN:    cls.kind = EV_IN;
      FUNC_RESET: cls.kind = EV_RESET;
      default:    cls.kind = EV_NAK;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign ev_valid = (count != 2'd0);
  assign ev       = q[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = ev_valid && ev_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ design/sbot_back.sv @@
// back part: protocol state and result generation, two-slot output register
module sbot_back #(
  parameter int BLOCK_BYTES  = 512,
  parameter int PACKET_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ev_valid,
  output logic                 ev_ready,
  input  sbot_pkg::event_t     ev,
  input  logic                 medium_ready,
  input  logic                 writable,
  input  logic [31:0]          capacity_blocks,
  output logic                 res_valid,
  input  logic                 res_ready,
  output sbot_pkg::result_t    res
);
  import sbot_pkg::*;

  localparam int PPB_RAW = BLOCK_BYTES / PACKET_BYTES;
  localparam int PPB     = (PPB_RAW < 1) ? 1 : PPB_RAW;
  localparam int PIW     = (PPB > 1) ? $clog2(PPB) : 1;
  localparam logic [6:0] PKT_LEN = 7'(PACKET_BYTES);
  localparam logic [6:0] PKT_CAP = 7'(PACKET_BYTES > 127 ? 127 : PACKET_BYTES);

  phase_t         phase, phase_next;
  logic [31:0]    saved_tag, saved_tag_next;
  logic [31:0]    cur_lba, cur_lba_next;
  logic [15:0]    blocks_left, blocks_left_next;
  logic [PIW-1:0] pkt_idx, pkt_idx_next;

  result_t        r0, r1;
  logic           two;
  // output slots: main register plus a second for the trailing csw
  result_t        out0, out1;
  logic           v0, v1;

  logic [31:0]    adv_lba;
  logic [15:0]    adv_left;
  logic [PIW-1:0] adv_idx;
  logic           adv_more;
  logic [6:0]     wlen;
  logic [63:0]    wp8;
  logic [8:0]     offs;

  assign ev_ready = !v1 && (!v0 || res_ready);

  // advance one packet slot
  always_comb begin
    adv_lba  = cur_lba;
    adv_left = blocks_left;
    adv_idx  = pkt_idx + PIW'(1);
    if (PPB == 1 || pkt_idx == PIW'(PPB - 1)) begin
      adv_idx  = '0;
      adv_lba  = cur_lba + 32'd1;
      adv_left = blocks_left - 16'd1;
    end
    adv_more = (adv_left != 16'd0);
  end

  assign wlen = (ev.len > PKT_CAP) ? PKT_CAP : ev.len;
  assign wp8  = writable ? 64'd0 : 64'h80;
  assign offs = 9'(32'(pkt_idx) * 32'(PACKET_BYTES));

  // decide results for the event at the head of the queue
  always_comb begin
    phase_next       = phase;
    saved_tag_next   = saved_tag;
    cur_lba_next     = cur_lba;
    blocks_left_next = blocks_left;
    pkt_idx_next     = pkt_idx;
    r0 = '0;
    r1 = '0;
    r0.action = ACT_NAK;
    r0.last   = 1'b1;
    r1.action = ACT_CSW;
    r1.last   = 1'b1;
    r1.status_tag = saved_tag;
    two = 1'b0;
    unique case (ev.kind)
      EV_RESET: begin
        phase_next       = PH_IDLE;
        saved_tag_next   = '0;
        cur_lba_next     = '0;
        blocks_left_next = '0;
        pkt_idx_next     = '0;
      end
      EV_OUT, EV_CBW: begin
        if (phase == PH_WRITE) begin
          r0.action        = ACT_WRITE;
          r0.block_address = cur_lba;
          r0.byte_offset   = offs;
          r0.packet_length = wlen;
          cur_lba_next     = adv_lba;
          blocks_left_next = adv_left;
          pkt_idx_next     = adv_idx;
          if (!adv_more) begin
            r0.last    = 1'b0;
            two        = 1'b1;
            phase_next = PH_STATUS;
          end
        end else if (ev.kind == EV_CBW) begin
          saved_tag_next = ev.tag;
          pkt_idx_next   = '0;
          r0.status_tag  = ev.tag;
          unique case (ev.op)
            OP_TUR: begin
              r0.action         = ACT_CSW;
              r0.status_residue = medium_ready ? 32'd0 : ev.dlen;
              r0.status_code    = ~medium_ready;
              phase_next        = PH_STATUS;
            end
            OP_SSU, OP_PAMR: begin
              r0.action  = ACT_CSW;
              phase_next = PH_STATUS;
            end
            OP_SENSE, OP_INQ, OP_MS6, OP_MS10, OP_CAP: begin
              r0.action     = ACT_RESP;
              r0.status_tag = '0;
              phase_next    = PH_RESP;
              unique case (ev.op)
                OP_SENSE: begin
                  r0.response_kind = RK_SENSE;
                  r0.packet_length = (PKT_CAP < 7'd18) ? PKT_CAP : 7'd18;
                end
                OP_INQ: begin
                  r0.response_kind = RK_INQ;
                  r0.packet_length = (PKT_CAP < 7'd36) ? PKT_CAP : 7'd36;
                end
                OP_MS6: begin
                  r0.response_kind = RK_MS6;
                  r0.packet_length = (PKT_CAP < 7'd4) ? PKT_CAP : 7'd4;
                  r0.response_word = (64'd3 << 56) | (wp8 << 40);
                end
                OP_MS10: begin
                  r0.response_kind = RK_MS10;
                  r0.packet_length = 7'd8;
                  r0.response_word = (64'd6 << 48) | (wp8 << 32);
                end
                default: begin
                  r0.response_kind = RK_CAP;
                  r0.packet_length = 7'd8;
                  r0.response_word = {capacity_blocks - 32'd1, 32'(BLOCK_BYTES)};
                end
              endcase
            end
            OP_READ, OP_WRITE: begin
              if (ev.nblk == 16'd0) begin
                r0.action  = ACT_CSW;
                phase_next = PH_STATUS;
              end else begin
                r0.status_tag    = '0;
                cur_lba_next     = ev.lba;
                blocks_left_next = ev.nblk;
                if (ev.op == OP_WRITE) begin
                  phase_next = PH_WRITE;
                end else begin
                  phase_next       = PH_READ;
                  r0.action        = ACT_READ;
                  r0.block_address = ev.lba;
                  r0.packet_length = PKT_LEN;
                end
              end
            end
            default: begin
              r0.action         = ACT_CSW;
              r0.status_residue = ev.dlen;
              r0.status_code    = 1'b1;
              phase_next        = PH_STATUS;
            end
          endcase
        end
      end
      EV_IN: begin
        if (phase == PH_READ) begin
          cur_lba_next     = adv_lba;
          blocks_left_next = adv_left;
          pkt_idx_next     = adv_idx;
          if (adv_more) begin
            r0.action        = ACT_READ;
            r0.block_address = adv_lba;
            r0.byte_offset   = 9'(32'(adv_idx) * 32'(PACKET_BYTES));
            r0.packet_length = PKT_LEN;
          end else begin
            r0.action     = ACT_CSW;
            r0.status_tag = saved_tag;
            phase_next    = PH_STATUS;
          end
        end else if (phase == PH_RESP) begin
          r0.action     = ACT_CSW;
          r0.status_tag = saved_tag;
          phase_next    = PH_STATUS;
        end else if (phase == PH_STATUS) begin
          phase_next = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  // protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      saved_tag   <= '0;
      cur_lba     <= '0;
      blocks_left <= '0;
      pkt_idx     <= '0;
    end else if (ev_valid && ev_ready) begin
      phase       <= phase_next;
      saved_tag   <= saved_tag_next;
      cur_lba     <= cur_lba_next;
      blocks_left <= blocks_left_next;
      pkt_idx     <= pkt_idx_next;
    end
  end

  // output slots
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (ev_valid && ev_ready) begin
      v0 <= 1'b1;
      v1 <= two;
    end else if (v0 && res_ready) begin
      v0 <= v1;
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && ev_ready) begin
      out0 <= r0;
      out1 <= r1;
    end else if (v0 && res_ready) begin
      out0 <= out1;
    end
  end

  assign res_valid = v0;
  assign res       = out0;
endmodule

@@ design/scsi_bulk_only_transport_engine_unit.sv @@
// top level of the usb mass storage bulk-only transport engine
//
//  channel  handshake            beat
//  in       in_valid/in_ready    one bulk endpoint event
//  out      out_valid/out_ready  one action result
//  cfg      cfg_we               register write (index, data)
//
// events are taken every cycle while the output register is free. a last
// write packet gives two beats, so that event holds the back part until its
// first beat is taken. a two-entry queue sits between the classifier and
// the protocol logic. reset is synchronous and clears state.
module scsi_bulk_only_transport_engine_unit #(
  parameter int BLOCK_BYTES  = 512,
  parameter int PACKET_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [6:0]  rx_length,
  input  logic [31:0] signature,
  input  logic [31:0] cbw_tag,
  input  logic [31:0] cbw_data_length,
  input  logic [7:0]  scsi_opcode,
  input  logic [31:0] start_lba,
  input  logic [15:0] block_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [31:0] block_address,
  output logic [8:0]  byte_offset,
  output logic [6:0]  packet_length,
  output logic [2:0]  response_kind,
  output logic [63:0] response_word,
  output logic [31:0] status_tag,
  output logic [31:0] status_residue,
  output logic        status_code,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sbot_pkg::*;

  logic        medium_ready, writable;
  logic [31:0] capacity_blocks;
  logic        ev_valid, ev_ready;
  event_t      ev;
  result_t     res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      medium_ready    <= 1'b0;
      writable        <= 1'b1;
      capacity_blocks <= 32'd1;
    end else if (cfg_we) begin
      if (cfg_index == REG_MEDIUM_READY) medium_ready <= cfg_data[0];
      if (cfg_index == REG_WRITABLE)     writable <= cfg_data[0];
      if (cfg_index == REG_CAPACITY)     capacity_blocks <= cfg_data;
    end
  end

  sbot_front u_front (
    .clk, .rst, .in_valid, .in_ready, .func, .rx_length, .signature,
    .cbw_tag, .cbw_data_length, .scsi_opcode, .start_lba, .block_count,
    .ev_valid, .ev_ready, .ev
  );

  sbot_back #(.BLOCK_BYTES(BLOCK_BYTES), .PACKET_BYTES(PACKET_BYTES)) u_back (
    .clk, .rst, .ev_valid, .ev_ready, .ev, .medium_ready, .writable,
    .capacity_blocks, .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign action         = res.action;
  assign block_address  = res.block_address;
  assign byte_offset    = res.byte_offset;
  assign packet_length  = res.packet_length;
  assign response_kind  = res.response_kind;
  assign response_word  = res.response_word;
  assign status_tag     = res.status_tag;
  assign status_residue = res.status_residue;
  assign status_code    = res.status_code;
  assign last           = res.last;

  // a non-final beat is always a storage write
  a_nonlast_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> action == ACT_WRITE)
    else $error("non-final beat that is not a write");

  // a non-final write is followed by a csw
  a_write_then_csw: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && action == ACT_CSW)
    else $error("csw missing after final write");

  // failed status only on csw
  a_fail_csw: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_code |-> action == ACT_CSW)
    else $error("failed status on non-csw beat");
endmodule
